>>> hw/rtl/mss_pkg.sv
// shared types, constants and helpers of the motor step response sequencer
`default_nettype none

package mss_pkg;

  // command codes as they arrive on the input stream and as classified by the front
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SET   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_WAIT    = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_CAPTURE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CAPTURE = 2'd1,
    KIND_MANUAL  = 2'd2
  } kind_e;

  // configuration register indexes (word address)
  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD   = 2'd0,
    REG_STEP_INTERVAL   = 2'd1,
    REG_REPORT_INTERVAL = 2'd2,
    REG_RPM_PER_PULSE   = 2'd3
  } reg_e;

  localparam logic [6:0]  DUTY_MAX        = 7'd100;
  localparam logic [31:0] SAMPLE_RST      = 32'd50000;
  localparam logic [31:0] STEP_RST        = 32'd2000000;
  localparam logic [31:0] REPORT_RST      = 32'd500000;
  localparam logic [15:0] RPM_RST         = 16'd15360;

  typedef struct packed {
    logic [31:0] sample_period;
    logic [31:0] step_interval;
    logic [31:0] report_interval;
    logic [15:0] rpm_per_pulse;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    cmd_e       cmd;
    logic       enc;
    logic [6:0] val;
    logic [6:0] rise;
  } item_t;

  typedef struct packed {
    logic [6:0]  duty_level;
    kind_e       kind;
    logic [31:0] elapsed;
    logic [6:0]  rec_duty;
    logic [31:0] speed;
    logic        done;
  } result_t;

  // peak step of the staircase for each step size: largest q with q * v <= 100
  typedef logic [6:0] rise_tbl_t [0:127];

  function automatic rise_tbl_t mk_rise_tbl();
    rise_tbl_t t;
    for (int v = 0; v < 128; v++) begin
      t[v] = 7'd0;
      for (int q = 0; q <= 100; q++) begin
        if (v != 0 && q * v <= 100) begin
          t[v] = 7'(q);
        end
      end
    end
    return t;
  endfunction

  localparam rise_tbl_t RISE_TBL = mk_rise_tbl();

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mss_front.sv
// front end: validates the command of an input beat and looks up the staircase peak
`default_nettype none

module mss_front (
  input  wire logic [1:0]   cmd_i,
  input  wire logic         enc_i,
  input  wire logic [7:0]   value_i,
  output mss_pkg::item_t    item_o
);
  import mss_pkg::*;

  always_comb begin
    item_o.cmd  = CMD_TICK;
    item_o.enc  = enc_i;
    item_o.val  = value_i[6:0];
    item_o.rise = 7'd0;
    case (cmd_i)
      CMD_START: begin
        if (value_i inside {[8'd1:8'd100]}) begin
          item_o.cmd  = CMD_START;
          item_o.rise = RISE_TBL[value_i[6:0]];
        end
      end
      CMD_SET: begin
        if (value_i <= {1'b0, DUTY_MAX}) begin
          item_o.cmd = CMD_SET;
        end
      end
      default: item_o.cmd = CMD_TICK;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mss_queue.sv
// two-entry queue between the front end and the back end
`default_nettype none

module mss_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire mss_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output mss_pkg::item_t      pop_item_o
);
  import mss_pkg::*;

  item_t      ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mss_back.sv
// back end: pulse counting, timers, mode and staircase, then the speed multiplier
`default_nettype none

module mss_back #(
  parameter int unsigned PULSE_COUNT_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mss_pkg::cfg_t  cfg_i,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire mss_pkg::item_t item_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output mss_pkg::result_t    res_o
);
  import mss_pkg::*;

  localparam int unsigned PCB    = PULSE_COUNT_BITS;
  localparam int unsigned PROD_W = PCB + 16;
  localparam logic [PCB-1:0] PC_MAX = {PCB{1'b1}};

  // architectural state
  logic           prev_q, prev_d;
  logic [PCB-1:0] pc_q, pc_d;
  mode_e          mode_q, mode_d;
  logic [31:0]    st_q, st_d, stp_q, stp_d, rt_q, rt_d, el_q, el_d;
  logic [7:0]     idx_q, idx_d, total_q, total_d;
  logic [6:0]     size_q, size_d, rise_q, rise_d, duty_q, duty_d;

  // stage a: record fields and pulse snapshot; stage b: output register
  logic           a_valid_q, b_valid_q;
  result_t        a_res_q, b_res_q, b_res_d;
  logic [PCB-1:0] a_pc_q;

  logic           a_ready, b_ready, pop;
  logic           is_start, is_set, inc, sample_due, step_due, step_end;
  logic [PCB-1:0] pc1, snap;
  mode_e          mode1;
  logic [31:0]    st1, stp1, rt1, el1, rec_el;
  logic [7:0]     idx1, idx2, total1, mul_a;
  logic [6:0]     size1, rise1, duty1, rec_duty;
  logic [14:0]    step_prod;
  kind_e          kind;
  logic [PROD_W-1:0] prod;
  logic [PCB+32:0]   prod_ext;

  assign b_ready      = !b_valid_q || res_ready_i;
  assign a_ready      = !a_valid_q || b_ready;
  assign item_ready_o = a_ready;
  assign pop          = item_valid_i && a_ready;

  // datapath of one tick
  always_comb begin
    is_start = (item_i.cmd == CMD_START);
    is_set   = (item_i.cmd == CMD_SET);
    inc      = item_i.enc && !prev_q && (pc_q != PC_MAX);
    prev_d   = item_i.enc;
    pc1      = is_start ? '0 : pc_q + PCB'(inc);
    st1      = is_start ? 32'd0 : sat_inc32(st_q);
    stp1     = is_start ? 32'd0 : sat_inc32(stp_q);
    rt1      = is_set ? 32'd0 : sat_inc32(rt_q);
    mode1    = is_start ? MODE_CAPTURE : (is_set ? MODE_MANUAL : mode_q);
    el1      = is_start ? 32'd0 : ((mode1 == MODE_CAPTURE) ? sat_inc32(el_q) : el_q);
    duty1    = is_start ? 7'd0 : (is_set ? item_i.val : duty_q);
    idx1     = is_start ? 8'd0 : idx_q;
    size1    = is_start ? item_i.val : size_q;
    rise1    = is_start ? item_i.rise : rise_q;
    total1   = is_start ? {item_i.rise, 1'b1} : total_q;

    // speed sample
    sample_due = (st1 >= cfg_i.sample_period);
    pc_d     = pc1;
    st_d     = st1;
    rt_d     = rt1;
    kind     = KIND_NONE;
    rec_el   = 32'd0;
    rec_duty = 7'd0;
    snap     = '0;
    if (sample_due) begin
      pc_d = '0;
      st_d = 32'd0;
      if (mode1 == MODE_CAPTURE) begin
        kind     = KIND_CAPTURE;
        rec_el   = el1;
        rec_duty = duty1;
        snap     = pc1;
      end else if (mode1 == MODE_MANUAL && rt1 >= cfg_i.report_interval) begin
        kind     = KIND_MANUAL;
        rec_duty = duty1;
        snap     = pc1;
        rt_d     = 32'd0;
      end
    end

    // staircase step, after the sample
    step_due  = (mode1 == MODE_CAPTURE) && (stp1 >= cfg_i.step_interval);
    idx2      = idx1 + 8'd1;
    mul_a     = (idx2 <= {1'b0, rise1}) ? idx2 : total1 - idx2;
    step_prod = mul_a * size1;
    stp_d     = stp1;
    idx_d     = idx1;
    duty_d    = duty1;
    step_end  = 1'b0;
    if (step_due) begin
      idx_d = idx2;
      if (idx2 < total1) begin
        duty_d = (step_prod > 15'(DUTY_MAX)) ? DUTY_MAX : step_prod[6:0];
        stp_d  = 32'd0;
      end else begin
        duty_d   = 7'd0;
        step_end = 1'b1;
      end
    end
    el_d    = el1;
    size_d  = size1;
    rise_d  = rise1;
    total_d = total1;
  end

  // next mode
  always_comb begin
    mode_d = step_end ? MODE_WAIT : mode1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      pc_q    <= '0;
      mode_q  <= MODE_WAIT;
      st_q    <= 32'd0;
      stp_q   <= 32'd0;
      rt_q    <= 32'd0;
      el_q    <= 32'd0;
      idx_q   <= 8'd0;
      size_q  <= 7'd0;
      rise_q  <= 7'd0;
      total_q <= 8'd0;
      duty_q  <= 7'd0;
    end else if (pop) begin
      prev_q  <= prev_d;
      pc_q    <= pc_d;
      mode_q  <= mode_d;
      st_q    <= st_d;
      stp_q   <= stp_d;
      rt_q    <= rt_d;
      el_q    <= el_d;
      idx_q   <= idx_d;
      size_q  <= size_d;
      rise_q  <= rise_d;
      total_q <= total_d;
      duty_q  <= duty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pop;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_res_q.duty_level <= duty_d;
      a_res_q.kind       <= kind;
      a_res_q.elapsed    <= rec_el;
      a_res_q.rec_duty   <= rec_duty;
      a_res_q.speed      <= 32'd0;
      a_res_q.done       <= step_end;
      a_pc_q             <= snap;
    end
  end

  // speed = pulses * rpm factor, saturated to 32 bits
  assign prod     = PROD_W'(a_pc_q) * PROD_W'(cfg_i.rpm_per_pulse);
  assign prod_ext = (PCB + 33)'(prod);

  always_comb begin
    b_res_d       = a_res_q;
    b_res_d.speed = (|prod_ext[PCB+32:32]) ? 32'hFFFF_FFFF : prod_ext[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_res_q <= b_res_d;
    end
  end

  assign res_valid_o = b_valid_q;
  assign res_o       = b_res_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_MAX)
    else $error("duty above full scale");

  a_done_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_res_q.done) |-> (a_res_q.duty_level == 7'd0))
    else $error("capture done with nonzero duty");

  a_done_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && step_end) |=> (mode_q == MODE_WAIT))
    else $error("staircase end did not return to wait");

  a_manual_no_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_res_q.kind == KIND_MANUAL) |-> (a_res_q.elapsed == 32'd0))
    else $error("manual report carries elapsed time");

endmodule

`default_nettype wire

>>> hw/rtl/motor_step_response_sequencer.sv
// top level of the motor step response sequencer: register file, front, queue, back
//
// channel   dir  beat contents (low bit first)
// s_axis    in   tdata: encoder_level, value; tuser: command
// m_axis    out  tdata: duty_level, elapsed_ticks, record_duty, speed_rpm_q8;
//                tuser: record_kind; tlast: capture_done
// apb       in   registers sample_period, step_interval, report_interval, rpm_per_pulse
//
// one input beat per cycle sustained while the output is not stalled, one result beat per input beat
// a beat passes the queue write, then the state update, then the speed multiply, each registered
// the state update of the back end sets the rate
// rst_ni clears all control state asynchronously; registers return to defaults
// a stalled output backs up through both back-end stages, then the two-entry
// queue takes two more beats before s_axis_tready drops
`default_nettype none

module motor_step_response_sequencer #(
  parameter int unsigned PULSE_COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [0] encoder_level, [8:1] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [6:0] duty_level, [38:7] elapsed_ticks,
                                           // [45:39] record_duty, [77:46] speed_rpm_q8
  output logic [1:0]       m_axis_tuser,   // [1:0] record_kind
  output logic             m_axis_tlast,   // capture_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mss_pkg::*;

  cfg_t    cfg_q;
  item_t   front_item, back_item;
  logic    back_valid, back_ready;
  result_t res;
  logic    cfg_wr;
  reg_e    reg_sel;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period   <= SAMPLE_RST;
      cfg_q.step_interval   <= STEP_RST;
      cfg_q.report_interval <= REPORT_RST;
      cfg_q.rpm_per_pulse   <= RPM_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SAMPLE_PERIOD:   cfg_q.sample_period   <= pwdata;
        REG_STEP_INTERVAL:   cfg_q.step_interval   <= pwdata;
        REG_REPORT_INTERVAL: cfg_q.report_interval <= pwdata;
        REG_RPM_PER_PULSE:   cfg_q.rpm_per_pulse   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SAMPLE_PERIOD:   prdata = cfg_q.sample_period;
      REG_STEP_INTERVAL:   prdata = cfg_q.step_interval;
      REG_REPORT_INTERVAL: prdata = cfg_q.report_interval;
      REG_RPM_PER_PULSE:   prdata = {16'd0, cfg_q.rpm_per_pulse};
      default:             prdata = 32'd0;
    endcase
  end

  // classify each input beat
  mss_front u_front (
    .cmd_i   (s_axis_tuser),
    .enc_i   (s_axis_tdata[0]),
    .value_i (s_axis_tdata[8:1]),
    .item_o  (front_item)
  );

  // decouple input acceptance from execution
  mss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  // tick execution and speed computation
  mss_back #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {2'b00, res.speed, res.rec_duty, res.elapsed, res.duty_level};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.done;

endmodule

`default_nettype wire

>>> bench/tb_motor_step_response_sequencer.sv
// testbench of the motor step response sequencer: stream driver, result monitor, predictor
`timescale 1ns / 1ps

module tb_motor_step_response_sequencer;
  import mss_pkg::*;

  // command code outside the defined set, must behave as a plain tick
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // let the pipeline registers settle, wait a little longer before touching registers
  localparam int DRAIN_PAD = 8;
  // rising edges gathered in manual mode while sampling is held off
  localparam int ACC_EDGES = 40;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enc;
    logic [7:0] val;
  } tick_beat_t;

  typedef struct packed {
    logic [6:0]  duty;
    logic [1:0]  kind;
    logic [31:0] elapsed;
    logic [6:0]  rec_duty;
    logic [31:0] speed;
    logic        done;
  } motor_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  motor_step_response_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ticks waiting to go out, and the records they must produce, oldest first
  tick_beat_t tick_backlog[$];
  motor_rec_t rec_expect[$];
  tick_beat_t bus_beat;
  logic       on_bus;

  int src_idle_pct;
  int snk_stall_pct;
  int mismatches;
  int unsigned cycle_count;

  // shadow copy of the registers
  logic [31:0] cfg_sample;
  logic [31:0] cfg_step;
  logic [31:0] cfg_report;
  logic [15:0] cfg_rpm;

  // shadow copy of the control state
  logic        enc_prev;
  logic [15:0] pulses;
  mode_e       mode_q;
  logic [31:0] sample_tmr;
  logic [31:0] step_tmr;
  logic [31:0] report_tmr;
  logic [31:0] run_elapsed;
  logic [7:0]  stair_idx;
  logic [6:0]  stair_step;
  logic [6:0]  stair_peak;
  logic [7:0]  stair_len;
  logic [6:0]  duty_now;

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // one tick of the sequencer: edge count, command, timers, sample, staircase
  function automatic motor_rec_t motor_predict(input tick_beat_t b);
    motor_rec_t  r;
    logic        hold_sample;
    logic        hold_step;
    logic        hold_report;
    logic        hold_elapsed;
    logic [63:0] prod;
    int          d;
    r = '0;
    hold_sample  = 1'b0;
    hold_step    = 1'b0;
    hold_report  = 1'b0;
    hold_elapsed = 1'b0;

    if (b.enc && !enc_prev && pulses != 16'hFFFF) begin
      pulses = pulses + 16'd1;
    end
    enc_prev = b.enc;

    if (b.cmd == CMD_START && b.val >= 8'd1 && b.val <= 8'd100) begin
      stair_step  = b.val[6:0];
      stair_peak  = 7'(100 / b.val);
      stair_len   = 8'(2 * stair_peak + 1);
      stair_idx   = '0;
      duty_now    = '0;
      pulses      = '0;
      run_elapsed = '0;
      step_tmr    = '0;
      sample_tmr  = '0;
      mode_q      = MODE_CAPTURE;
      hold_sample  = 1'b1;
      hold_step    = 1'b1;
      hold_elapsed = 1'b1;
    end else if (b.cmd == CMD_SET && b.val <= 8'd100) begin
      duty_now    = b.val[6:0];
      report_tmr  = '0;
      mode_q      = MODE_MANUAL;
      hold_report = 1'b1;
    end

    if (!hold_sample) sample_tmr = bump32(sample_tmr);
    if (!hold_step) step_tmr = bump32(step_tmr);
    if (!hold_report) report_tmr = bump32(report_tmr);
    if (!hold_elapsed && mode_q == MODE_CAPTURE) run_elapsed = bump32(run_elapsed);

    if (sample_tmr >= cfg_sample) begin
      prod = 64'(pulses) * 64'(cfg_rpm);
      if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
      pulses     = '0;
      sample_tmr = '0;
      if (mode_q == MODE_CAPTURE) begin
        r.kind     = KIND_CAPTURE;
        r.elapsed  = run_elapsed;
        r.rec_duty = duty_now;
        r.speed    = prod[31:0];
      end else if (mode_q == MODE_MANUAL && report_tmr >= cfg_report) begin
        r.kind     = KIND_MANUAL;
        r.rec_duty = duty_now;
        r.speed    = prod[31:0];
        report_tmr = '0;
      end
    end

    // staircase moves after the sample, so a sample sees the old duty
    if (mode_q == MODE_CAPTURE && step_tmr >= cfg_step) begin
      stair_idx = stair_idx + 8'd1;
      if (stair_idx < stair_len) begin
        d = (stair_idx <= stair_peak) ? int'(stair_idx) * int'(stair_step)
                                      : int'(stair_len - stair_idx) * int'(stair_step);
        duty_now = (d > 100) ? 7'd100 : 7'(d);
        step_tmr = '0;
      end else begin
        duty_now = '0;
        mode_q   = MODE_WAIT;
        r.done   = 1'b1;
      end
    end

    r.duty = duty_now;
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_motor_step_response_sequencer: FAIL");
      $finish;
    end
  end

  // input side: holds a beat until taken, then loads the next one or idles
  always @(posedge clk_i) begin : tick_driver
    logic load;
    if (s_axis_tvalid && s_axis_tready) begin
      rec_expect.push_back(motor_predict(bus_beat));
      on_bus = 1'b0;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      load = rst_ni && tick_backlog.size() != 0 &&
             ($urandom_range(99) >= src_idle_pct);
      if (load) begin
        bus_beat = tick_backlog.pop_front();
        on_bus   = 1'b1;
        s_axis_tdata  <= {7'd0, bus_beat.val, bus_beat.enc};
        s_axis_tuser  <= bus_beat.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random back-pressure and in-order compare
  always @(posedge clk_i) begin : rec_monitor
    motor_rec_t got;
    motor_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.duty     = m_axis_tdata[6:0];
      got.elapsed  = m_axis_tdata[38:7];
      got.rec_duty = m_axis_tdata[45:39];
      got.speed    = m_axis_tdata[77:46];
      got.kind     = m_axis_tuser;
      got.done     = m_axis_tlast;
      if (rec_expect.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat: duty=%0d kind=%0d elapsed=%0d",
                   got.duty, got.kind, got.elapsed);
          $display("  rduty=%0d speed=%h done=%0d", got.rec_duty, got.speed, got.done);
        end
        mismatches <= mismatches + 1;
      end else begin
        want = rec_expect.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected duty=%0d kind=%0d elapsed=%0d rduty=%0d speed=%h done=%0d",
                     want.duty, want.kind, want.elapsed, want.rec_duty, want.speed, want.done);
            $display("  actual   duty=%0d kind=%0d elapsed=%0d rduty=%0d speed=%h done=%0d",
                     got.duty, got.kind, got.elapsed, got.rec_duty, got.speed, got.done);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic add_beat(input logic [1:0] cmd, input logic enc, input logic [7:0] val);
    tick_beat_t b;
    b.cmd = cmd;
    b.enc = enc;
    b.val = val;
    tick_backlog.push_back(b);
  endtask

  // every queued tick sent and every record back, then let the pipe settle
  task automatic wait_drained();
    while (tick_backlog.size() != 0 || on_bus || rec_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // setup then access, register taken at the access edge
  task automatic reg_write(input reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SAMPLE_PERIOD:   cfg_sample = data;
      REG_STEP_INTERVAL:   cfg_step   = data;
      REG_REPORT_INTERVAL: cfg_report = data;
      default:             cfg_rpm    = data[15:0];
    endcase
  endtask

  task automatic write_all(input logic [31:0] sp, input logic [31:0] st,
                           input logic [31:0] rp, input logic [15:0] rpm);
    reg_write(REG_SAMPLE_PERIOD, sp);
    reg_write(REG_STEP_INTERVAL, st);
    reg_write(REG_REPORT_INTERVAL, rp);
    reg_write(REG_RPM_PER_PULSE, {16'd0, rpm});
  endtask

  // mostly plain ticks with a live encoder, sprinkled starts and sets,
  // a few malformed commands
  task automatic gen_ticks(input int n);
    int unsigned r;
    logic [7:0]  v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(999);
      if (r < 12) begin
        if (r < 2) v = $urandom_range(1) ? 8'd0 : 8'($urandom_range(101, 255));
        else if ($urandom_range(9) == 0) v = 8'($urandom_range(1, 9));
        else v = 8'($urandom_range(10, 100));
        add_beat(CMD_START, 1'($urandom_range(1)), v);
      end else if (r < 24) begin
        v = (r < 15) ? 8'($urandom_range(101, 255)) : 8'($urandom_range(0, 100));
        add_beat(CMD_SET, 1'($urandom_range(1)), v);
      end else if (r < 30) begin
        add_beat(CMD_SPARE, 1'($urandom_range(1)), 8'($urandom));
      end else begin
        add_beat(CMD_TICK, 1'($urandom_range(1)), 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct,
                           input logic [31:0] sp, input logic [31:0] st,
                           input logic [31:0] rp, input logic [15:0] rpm,
                           input int n, input bit pause_midway);
    wait_drained();
    write_all(sp, st, rp, rpm);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    gen_ticks(n / 2);
    // sender holds off until every record is back, then carries on
    if (pause_midway) wait_drained();
    gen_ticks(n - n / 2);
  endtask

  initial begin : test_main
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    on_bus        = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    cfg_sample  = SAMPLE_RST;
    cfg_step    = STEP_RST;
    cfg_report  = REPORT_RST;
    cfg_rpm     = RPM_RST;
    enc_prev    = 1'b0;
    pulses      = '0;
    mode_q      = MODE_WAIT;
    sample_tmr  = '0;
    step_tmr    = '0;
    report_tmr  = '0;
    run_elapsed = '0;
    stair_idx   = '0;
    stair_step  = '0;
    stair_peak  = '0;
    stair_len   = '0;
    duty_now    = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero periods: every event due on every tick, the command tick too
    write_all(32'd0, 32'd0, 32'd0, 16'hFFFF);
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_TICK, 1'b1, 8'hFF);
    add_beat(CMD_TICK, 1'b0, 8'd0);
    add_beat(CMD_START, 1'b0, 8'd1);      // smallest step, longest staircase
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_TICK, 1'b0, 8'd0);
    add_beat(CMD_START, 1'b1, 8'd100);    // restart mid capture, one step to peak
    add_beat(CMD_TICK, 1'b0, 8'd0);
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_TICK, 1'b0, 8'd0);
    add_beat(CMD_START, 1'b0, 8'd0);      // out of range starts are plain ticks
    add_beat(CMD_START, 1'b1, 8'd101);
    add_beat(CMD_START, 1'b0, 8'd255);
    add_beat(CMD_SPARE, 1'b1, 8'd5);
    add_beat(CMD_SET, 1'b0, 8'd0);
    add_beat(CMD_SET, 1'b1, 8'd100);
    add_beat(CMD_SET, 1'b0, 8'd101);      // out of range sets are plain ticks
    add_beat(CMD_SET, 1'b1, 8'd255);
    add_beat(CMD_START, 1'b0, 8'd50);     // start from manual
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_SET, 1'b0, 8'd37);       // set aborts capture, no done
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_START, 1'b0, 8'd33);
    add_beat(CMD_TICK, 1'b1, 8'd0);
    add_beat(CMD_TICK, 1'b0, 8'd0);
    wait_drained();

    // pulse gathering: manual mode, sampling held off, encoder toggling
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);
    add_beat(CMD_SET, 1'b0, 8'd50);
    for (int i = 0; i < ACC_EDGES; i++) begin
      add_beat(CMD_TICK, 1'b1, 8'd0);
      add_beat(CMD_TICK, 1'b0, 8'd0);
    end
    wait_drained();
    // now sample at once, the gathered count shows up in a manual report
    reg_write(REG_SAMPLE_PERIOD, 32'd1);
    for (int i = 0; i < 4; i++) add_beat(CMD_TICK, 1'(i), 8'd0);

    // random traffic under the four idling patterns
    run_phase(0, 0, 32'd1, 32'd3, 32'd2, 16'($urandom), 400, 1'b0);
    run_phase(83, 0, 32'd4, 32'd2, 32'd10, 16'hFFFF, 400, 1'b1);
    run_phase(0, 83, 32'd2, 32'd1, 32'd1, 16'd0, 400, 1'b0);
    run_phase(28, 28, 32'($urandom_range(1, 6)), 32'($urandom_range(1, 5)),
              32'($urandom_range(1, 20)), 16'($urandom), 400, 1'b0);
    wait_drained();

    if (mismatches == 0 && rec_expect.size() == 0) begin
      $display("tb_motor_step_response_sequencer: PASS");
    end else begin
      $display("tb_motor_step_response_sequencer: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_front.sv
hw/rtl/mss_queue.sv
hw/rtl/mss_back.sv
hw/rtl/motor_step_response_sequencer.sv
bench/tb_motor_step_response_sequencer.sv
